FILE: design/psrq_pkg.sv
// Package for the packet slot ring queue.
// Sizes, command and status codes, and the queue entry type.
// No dependencies; every other file in the design imports it.
`timescale 1ns / 1ps

package psrq_pkg;

  // Ring geometry
  localparam int SlotCount = 8;
  localparam int SlotBytes = 64;

  localparam int IdxW  = $clog2(SlotCount);
  localparam int OffW  = $clog2(SlotBytes);
  localparam int CntW  = $clog2(SlotBytes + 1);
  localparam int AddrW = $clog2(SlotCount * SlotBytes);

  // Command queue between front and back
  localparam int CmdqDepth = 2;
  localparam int CmdqPtrW  = $clog2(CmdqDepth);
  localparam int CmdqCntW  = $clog2(CmdqDepth + 1);

  // Function codes on func_i
  typedef enum logic [1:0] {
    FUNC_POST  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_LONG  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Decoded command kinds
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_kind_e;

  // Back end sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } back_state_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       byte_valid;
  } cmd_t;

  // Next slot index around the ring
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    next_idx = (i == IdxW'(SlotCount - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

FILE: design/psrq_front.sv
// Front end of the packet slot ring queue: accepts items and decodes
// them into queue commands. Depends on psrq_pkg.
`timescale 1ns / 1ps

module psrq_front (
  input  logic              start_i,
  input  logic [1:0]        func_i,
  input  logic [7:0]        data_i,
  input  logic              byte_valid_i,
  input  logic              last_i,
  output logic              busy_o,
  input  logic              full_i,
  output logic              push_o,
  output psrq_pkg::cmd_t    cmd_o
);
  import psrq_pkg::*;

  logic accept;

  // Hold off new items while the command queue has no room
  assign busy_o = full_i;
  assign accept = start_i && !full_i;

  // Decode; unknown function codes are dropped here
  always_comb begin
    push_o           = 1'b0;
    cmd_o.kind       = CMD_BYTE;
    cmd_o.data       = data_i;
    cmd_o.byte_valid = byte_valid_i;
    case (func_e'(func_i))
      FUNC_POST: begin
        push_o     = accept;
        cmd_o.kind = last_i ? CMD_END : CMD_BYTE;
      end
      FUNC_READ: begin
        push_o     = accept;
        cmd_o.kind = CMD_READ;
      end
      FUNC_CLEAR: begin
        push_o     = accept;
        cmd_o.kind = CMD_CLEAR;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/psrq_cmdq.sv
// Short command queue between front and back end.
// Depends on psrq_pkg for depth and entry type.
`timescale 1ns / 1ps

module psrq_cmdq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  psrq_pkg::cmd_t    cmd_i,
  output logic              full_o,
  output logic              valid_o,
  output psrq_pkg::cmd_t    cmd_o,
  input  logic              pop_i
);
  import psrq_pkg::*;

  cmd_t                entry_q [CmdqDepth];
  logic [CmdqPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdqPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdqCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CmdqCntW'(CmdqDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CmdqPtrW'(CmdqDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CmdqPtrW'(CmdqDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, payload only
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: design/psrq_back.sv
// Back end of the packet slot ring queue: ring indices, slot memories,
// post assembly and read streaming, plus the result pipeline.
// Depends on psrq_pkg.
`timescale 1ns / 1ps

module psrq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  psrq_pkg::cmd_t    cmd_i,
  output logic              pop_o,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [7:0]        out_byte_o,
  output logic              end_of_run_o,
  output logic              space_left_o,
  output logic              data_waiting_o
);
  import psrq_pkg::*;

  // Ring and post state
  back_state_e     state_q, state_d;
  logic [IdxW-1:0] wi_q, wi_d;
  logic [IdxW-1:0] ri_q, ri_d;
  logic [CntW-1:0] pc_q, pc_d;
  logic            long_q, long_d;
  logic [OffW-1:0] rcnt_q, rcnt_d;

  // Slot memories
  logic [7:0]      mem_q [SlotCount * SlotBytes];
  logic [OffW-1:0] len_mem_q [SlotCount];
  logic            mem_we, len_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [OffW-1:0] len_wdata;
  logic [7:0]      byte_rd_q;
  logic [OffW-1:0] len_rd_q;

  // Post byte bookkeeping
  logic            pc_inc;
  logic [CntW-1:0] pc_new;
  logic            long_new;
  logic            has_data;

  // Result stage 1 (memory read in flight)
  logic            s1_vld_q, s1_vld_d;
  status_e         s1_status_q, s1_status_d;
  logic            s1_rd_q, s1_rd_d;
  logic [OffW-1:0] s1_off_q, s1_off_d;
  logic            s1_end_q, s1_end_d;
  logic            s1_space_q, s1_space_d;
  logic            s1_wait_q, s1_wait_d;

  // Output registers
  logic            done_q;
  status_e         status_q;
  logic [7:0]      byte_q;
  logic            end_q, space_q, wait_q;

  assign has_data = (next_idx(ri_q) != wi_q);
  assign pc_inc   = cmd_i.byte_valid && (pc_q < CntW'(SlotBytes));
  assign pc_new   = pc_q + CntW'(pc_inc);
  assign long_new = long_q || (cmd_i.byte_valid && (pc_new >= CntW'(SlotBytes)));

  assign mem_waddr = AddrW'(wi_q) * AddrW'(SlotBytes) + AddrW'(pc_q[OffW-1:0]);
  assign mem_raddr = AddrW'(ri_q) * AddrW'(SlotBytes) + AddrW'(rcnt_q);
  assign len_wdata = pc_new[OffW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == CMD_READ) && has_data) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (rcnt_q == OffW'(SlotBytes - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command execution
  always_comb begin
    wi_d        = wi_q;
    ri_d        = ri_q;
    pc_d        = pc_q;
    long_d      = long_q;
    rcnt_d      = rcnt_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    len_we      = 1'b0;
    s1_vld_d    = 1'b0;
    s1_status_d = ST_OK;
    s1_rd_d     = 1'b0;
    s1_off_d    = rcnt_q;
    s1_end_d    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_BYTE: begin
              mem_we = pc_inc;
              pc_d   = pc_new;
              long_d = long_new;
            end
            CMD_END: begin
              mem_we   = pc_inc;
              pc_d     = '0;
              long_d   = 1'b0;
              s1_vld_d = 1'b1;
              s1_end_d = 1'b1;
              if (wi_q == ri_q) begin
                s1_status_d = ST_FULL;
              end else if (long_new) begin
                s1_status_d = ST_LONG;
              end else begin
                len_we = 1'b1;
                wi_d   = next_idx(wi_q);
              end
            end
            CMD_READ: begin
              if (!has_data) begin
                s1_vld_d    = 1'b1;
                s1_end_d    = 1'b1;
                s1_status_d = ST_EMPTY;
              end else begin
                ri_d   = next_idx(ri_q);
                rcnt_d = '0;
              end
            end
            CMD_CLEAR: begin
              wi_d     = '0;
              ri_d     = IdxW'(SlotCount - 1);
              pc_d     = '0;
              long_d   = 1'b0;
              s1_vld_d = 1'b1;
              s1_end_d = 1'b1;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        s1_vld_d = 1'b1;
        s1_rd_d  = 1'b1;
        s1_end_d = (rcnt_q == OffW'(SlotBytes - 1));
        rcnt_d   = rcnt_q + 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
    s1_space_d = (wi_d != ri_d);
    s1_wait_d  = (next_idx(ri_d) != wi_d);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wi_q     <= '0;
      ri_q     <= IdxW'(SlotCount - 1);
      pc_q     <= '0;
      long_q   <= 1'b0;
      rcnt_q   <= '0;
      s1_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      wi_q     <= wi_d;
      ri_q     <= ri_d;
      pc_q     <= pc_d;
      long_q   <= long_d;
      rcnt_q   <= rcnt_d;
      s1_vld_q <= s1_vld_d;
      done_q   <= s1_vld_q;
    end
  end

  // Slot byte memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= cmd_i.data;
    end
    byte_rd_q <= mem_q[mem_raddr];
  end

  // Slot length memory, registered read
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem_q[wi_q] <= len_wdata;
    end
    len_rd_q <= len_mem_q[ri_q];
  end

  // Result payload pipeline; bytes past the stored length read as zero
  always_ff @(posedge clk_i) begin
    s1_status_q <= s1_status_d;
    s1_rd_q     <= s1_rd_d;
    s1_off_q    <= s1_off_d;
    s1_end_q    <= s1_end_d;
    s1_space_q  <= s1_space_d;
    s1_wait_q   <= s1_wait_d;
    status_q    <= s1_status_q;
    byte_q      <= (s1_rd_q && (s1_off_q < len_rd_q)) ? byte_rd_q : 8'd0;
    end_q       <= s1_end_q;
    space_q     <= s1_space_q;
    wait_q      <= s1_wait_q;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_byte_o     = byte_q;
  assign end_of_run_o   = end_q;
  assign space_left_o   = space_q;
  assign data_waiting_o = wait_q;

  // A ring is never both full and empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (space_q || wait_q))
    else $error("result reports neither space nor data");

  // An empty report is always a single final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == ST_EMPTY)) |-> end_q)
    else $error("empty result without end mark");

  // Only successful reads carry data bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q != ST_OK)) |-> (byte_q == 8'd0))
    else $error("non-zero byte on a failed result");

  // No command is taken while a packet streams out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !pop_o)
    else $error("command popped during read stream");

  // Post byte count never passes the slot size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= CntW'(SlotBytes))
    else $error("post byte count out of range");

endmodule

FILE: design/packet_slot_ring_queue.sv
// Top level of the packet slot ring queue: front decoder, command queue
// and back end. Depends on psrq_pkg, psrq_front, psrq_cmdq, psrq_back.
`timescale 1ns / 1ps

// A ring of SlotCount packet slots of SlotBytes bytes each, holding at
// most SlotCount - 1 packets. Items are taken when start_i is high and
// busy_o is low; busy_o rises only when the two-entry command queue is
// full. Post bytes, post ends and clears never hold the back end, so a
// stream of them is accepted at one item per cycle. A read of a stored
// packet holds the back end while it takes the command and then streams
// one slot byte per cycle through the single read port of the slot
// memory, during which the queue fills and busy_o stalls the sender.
// Each result appears on the output ports for one cycle with done_o
// high. A post end, a clear or an empty read gives its result through
// the stage 1 and output registers after the back end takes its command;
// the bytes of a read follow through the same registers, one per cycle.
// The receiver cannot stall. Post bytes without a last mark give no
// result, nor do unknown function codes.
module packet_slot_ring_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] func_i,
  input  logic [7:0] data_i,
  input  logic       byte_valid_i,
  input  logic       last_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [7:0] out_byte_o,
  output logic       end_of_run_o,
  output logic       space_left_o,
  output logic       data_waiting_o
);
  import psrq_pkg::*;

  logic full, push, cmd_valid, pop;
  cmd_t push_cmd, head_cmd;

  psrq_front u_front (
    .start_i      (start_i),
    .func_i       (func_i),
    .data_i       (data_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .busy_o       (busy_o),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  psrq_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  psrq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_byte_o     (out_byte_o),
    .end_of_run_o   (end_of_run_o),
    .space_left_o   (space_left_o),
    .data_waiting_o (data_waiting_o)
  );

endmodule

FILE: tb/packet_slot_ring_queue_tb.sv
// Testbench for packet_slot_ring_queue: directed and random post, read and clear
// items, checked result by result against a scoreboard that mirrors the slot ring.
// Depends on psrq_pkg and the packet_slot_ring_queue RTL.
`timescale 1ns / 1ps

module packet_slot_ring_queue_tb;
  import psrq_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 5;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 16;

  // func code the block ignores
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       space_left;
    logic       data_waiting;
  } slot_result_t;

  // Mirror of the slot ring plus the queue of results still owed by the block
  class ring_queue_scoreboard;
    logic [7:0]      slot_mem [SlotCount][SlotBytes];
    logic [CntW-1:0] slot_len [SlotCount];
    logic [IdxW-1:0] wr_idx;
    logic [IdxW-1:0] rd_idx;
    int unsigned     post_cnt;
    bit              post_long;
    slot_result_t    owed_q[$];
    int              errors;
    int              result_no;

    function new();
      errors    = 0;
      result_no = 0;
      empty_ring();
    endfunction

    function void empty_ring();
      foreach (slot_mem[s, b]) slot_mem[s][b] = 8'h00;
      foreach (slot_len[s]) slot_len[s] = '0;
      wr_idx    = '0;
      rd_idx    = IdxW'(SlotCount - 1);
      post_cnt  = 0;
      post_long = 1'b0;
    endfunction

    function logic [IdxW-1:0] ring_next(logic [IdxW-1:0] i);
      return (int'(i) + 1 >= SlotCount) ? '0 : i + 1'b1;
    endfunction

    // flags reflect the indices after the step
    function void push_result(status_e st, logic [7:0] b, logic eor);
      slot_result_t r;
      r.status       = st;
      r.out_byte     = b;
      r.end_of_run   = eor;
      r.space_left   = (wr_idx != rd_idx);
      r.data_waiting = (ring_next(rd_idx) != wr_idx);
      owed_q.push_back(r);
    endfunction

    // Predict the results of one accepted item
    function void note_item(logic [1:0] func, logic [7:0] data, logic bv, logic last);
      status_e st;
      case (func)
        FUNC_POST: begin
          if (bv) begin
            if (post_cnt < SlotBytes) begin
              slot_mem[wr_idx][post_cnt] = data;
              post_cnt++;
            end
            if (post_cnt >= SlotBytes) post_long = 1'b1;
          end
          if (last) begin
            // full wins over too long
            if (wr_idx == rd_idx) begin
              st = ST_FULL;
            end else if (post_long) begin
              st = ST_LONG;
            end else begin
              slot_len[wr_idx] = CntW'(post_cnt);
              wr_idx = ring_next(wr_idx);
              st = ST_OK;
            end
            post_cnt  = 0;
            post_long = 1'b0;
            push_result(st, 8'h00, 1'b1);
          end
        end
        FUNC_READ: begin
          if (ring_next(rd_idx) == wr_idx) begin
            push_result(ST_EMPTY, 8'h00, 1'b1);
          end else begin
            rd_idx = ring_next(rd_idx);
            for (int i = 0; i < SlotBytes; i++)
              push_result(ST_OK, (i < int'(slot_len[rd_idx])) ? slot_mem[rd_idx][i] : 8'h00,
                          i == SlotBytes - 1);
          end
        end
        FUNC_CLEAR: begin
          empty_ring();
          push_result(ST_OK, 8'h00, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH @%0t result %0d: %s", $time, result_no, msg);
    endtask

    task check_result(logic [1:0] st, logic [7:0] ob, logic eor, logic sp, logic dw);
      slot_result_t want;
      result_no++;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d byte=%02h", st, ob));
        return;
      end
      want = owed_q.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", st, want.status));
      if (ob !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, want %02h", ob, want.out_byte));
      if (eor !== want.end_of_run)
        report_mismatch($sformatf("end_of_run %0b, want %0b", eor, want.end_of_run));
      if (sp !== want.space_left)
        report_mismatch($sformatf("space_left %0b, want %0b", sp, want.space_left));
      if (dw !== want.data_waiting)
        report_mismatch($sformatf("data_waiting %0b, want %0b", dw, want.data_waiting));
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic [1:0] func_i = '0;
  logic [7:0] data_i = '0;
  logic       byte_valid_i = 1'b0;
  logic       last_i = 1'b0;
  logic       busy_o;
  logic       done_o;
  logic [1:0] status_o;
  logic [7:0] out_byte_o;
  logic       end_of_run_o;
  logic       space_left_o;
  logic       data_waiting_o;

  ring_queue_scoreboard sb;
  int sender_idle_pct = 0;
  int quiet_cycles = 0;

  packet_slot_ring_queue uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .data_i         (data_i),
    .byte_valid_i   (byte_valid_i),
    .last_i         (last_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_byte_o     (out_byte_o),
    .end_of_run_o   (end_of_run_o),
    .space_left_o   (space_left_o),
    .data_waiting_o (data_waiting_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result(status_o, out_byte_o, end_of_run_o, space_left_o, data_waiting_o);
  end

  // Watchdog: cycles with neither an accepted item nor a result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive one item and hold it until taken; random sender gaps first
  task automatic send_item(logic [1:0] func, logic [7:0] data, logic bv, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i      <= 1'b0;
      func_i       <= 2'($urandom);
      data_i       <= 8'($urandom);
      byte_valid_i <= 1'($urandom);
      last_i       <= 1'($urandom);
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    func_i       <= func;
    data_i       <= data;
    byte_valid_i <= bv;
    last_i       <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_item(func, data, bv, last);
  endtask

  // n bytes, then last; fill < 0 gives random bytes. Sometimes the last mark
  // rides on a separate empty item, and empty items are mixed in.
  task automatic post_packet(int n, int fill);
    logic [7:0] b;
    bit         tail_empty;
    tail_empty = (n == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_item(FUNC_POST, 8'($urandom), 1'b0, 1'b0);
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      send_item(FUNC_POST, b, 1'b1, !tail_empty && (i == n - 1));
    end
    if (tail_empty) send_item(FUNC_POST, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic read_packet();
    send_item(FUNC_READ, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic clear_queue();
    send_item(FUNC_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Short packets only; the long ones come from the directed part
  function automatic int packet_length();
    return $urandom_range(8);
  endfunction

  task automatic random_ops(int ops, int idle_pct);
    int pick;
    sender_idle_pct = idle_pct;
    repeat (ops) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        post_packet(packet_length(), -1);
      end else if (pick < 80) begin
        read_packet();
      end else if (pick < 85) begin
        clear_queue();
      end else if (pick < 91) begin
        send_item(FUNC_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 95) begin
        send_item(FUNC_POST, 8'($urandom), 1'b0, 1'b0);
      end else begin
        // post cut short by a clear
        repeat ($urandom_range(5, 1)) send_item(FUNC_POST, 8'($urandom), 1'b1, 1'b0);
        clear_queue();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    sender_idle_pct = 25;
    read_packet();                         // empty queue
    post_packet(0, -1);                    // empty packet
    read_packet();                         // padding only
    post_packet(1, 8'hFF);
    post_packet(SlotBytes + 1, 8'hFF);     // too long; count saturates
    read_packet();
    read_packet();                         // empty again
    for (int k = 0; k < SlotCount - 1; k++)
      post_packet(k % 3, k[0] ? 8'hFF : 8'h00);
    send_item(FUNC_POST, 8'hA5, 1'b1, 1'b0);  // byte into the free slot while full
    post_packet(2, -1);                    // full
    read_packet();
    post_packet(3, -1);
    send_item(FUNC_UNUSED, 8'hFF, 1'b1, 1'b1);
    clear_queue();
    read_packet();
    repeat (3) send_item(FUNC_POST, 8'($urandom), 1'b1, 1'b0);
    clear_queue();                         // drops the post in progress
    post_packet(2, -1);
    read_packet();

    // Random part in three idle profiles
    random_ops(5, 25);
    random_ops(5, 88);
    random_ops(5, 0);

    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/psrq_pkg.sv
design/psrq_front.sv
design/psrq_cmdq.sv
design/psrq_back.sv
design/packet_slot_ring_queue.sv
tb/packet_slot_ring_queue_tb.sv
